>>> src/news_idx_pkg.sv
package news_idx_pkg;

    typedef enum logic [3:0] {
        ST_NAME     = 4'd0,
        ST_LF       = 4'd1,
        ST_ROOT     = 4'd2,
        ST_ROOT_GOT = 4'd3,
        ST_LF_GOT   = 4'd4,
        ST_S        = 4'd5,
        ST_U        = 4'd6,
        ST_B        = 4'd7,
        ST_J        = 4'd8,
        ST_E        = 4'd9,
        ST_C        = 4'd10,
        ST_T        = 4'd11,
        ST_COPY     = 4'd12,
        ST_PERIOD   = 4'd13
    } scan_state_t;

    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_LF     = 8'd10;
    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_PERIOD = 8'h2e;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic KIND_TITLE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  title_byte;
        logic [31:0] article_start;
        logic [31:0] article_length;
        logic        line_end_is_cr;
        logic        last;
    } result_t;

    // Expected upper-case letter of "SUBJECT" that follows the given match state.
    function automatic logic [7:0] kw_char(input scan_state_t st);
        logic [7:0] ch;
        begin
            case (st)
                ST_S:    ch = 8'h55;  // U
                ST_U:    ch = 8'h42;  // B
                ST_B:    ch = 8'h4a;  // J
                ST_J:    ch = 8'h45;  // E
                ST_E:    ch = 8'h43;  // C
                ST_C:    ch = 8'h54;  // T
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

>>> src/news_article_index_scanner.sv
// News article index scanner. Takes the news file one byte per item on the
// input channel and emits one result item per title byte (group name, a colon,
// two spaces, then the Subject text, capped at TITLE_MAX bytes) plus one end
// record per article when the terminator of a lone period line arrives. Each
// input byte waits in the input register until the scan stage takes it, and
// its results are written into a four-entry result queue whose head drives
// the outputs. A byte that ends a name line can queue up to three results;
// the queue drains one item per cycle while out_stall is low. Input throughput
// is one byte per cycle as long as results are taken; it drops only while the
// queue holds more than two pending results, as after a name line end.
module news_article_index_scanner #(
    parameter int TITLE_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  title_byte,
    output logic [31:0] article_start,
    output logic [31:0] article_length,
    output logic        line_end_is_cr,
    output logic        last
);

    localparam int CW    = $clog2(TITLE_MAX + 1);
    localparam int DEPTH = 4;
    localparam int PW    = 2;
    localparam int QW    = 3;

    logic                      in_valid_reg;
    logic [7:0]                in_byte_reg;
    news_idx_pkg::scan_state_t state_reg, state_next;
    logic [31:0]               pos_reg;
    logic [31:0]               body_start_reg, body_start_next;
    logic [CW-1:0]             title_count_reg, title_count_next;
    logic                      cr_seen_reg, cr_seen_next;

    news_idx_pkg::result_t     queue_mem [DEPTH];
    logic [PW-1:0]             wr_ptr_reg;
    logic [PW-1:0]             rd_ptr_reg;
    logic [QW-1:0]             count_reg;

    news_idx_pkg::result_t     res [3];
    logic [1:0]                n_res;
    logic [QW-1:0]             space;
    logic                      pop;
    logic                      proc_fire;
    logic                      accept;

    logic [7:0]                c;
    logic [7:0]                up;
    logic                      eol;
    logic [CW:0]               room;
    logic [1:0]                n_title;
    logic [31:0]               next_pos;

    assign pop       = out_valid && !out_stall;
    assign space     = QW'(DEPTH) - count_reg + QW'(pop);
    assign proc_fire = in_valid_reg && (space >= QW'(3));
    assign in_stall  = in_valid_reg && !proc_fire;
    assign accept    = in_valid && !in_stall;

    assign c        = in_byte_reg;
    assign eol      = (c == news_idx_pkg::CHAR_CR) || (c == news_idx_pkg::CHAR_LF);
    assign up       = (c >= news_idx_pkg::CHAR_LOW_A && c <= news_idx_pkg::CHAR_LOW_Z)
                      ? c - news_idx_pkg::CASE_OFFSET : c;
    assign room     = (CW+1)'(TITLE_MAX) - {1'b0, title_count_reg};
    assign next_pos = pos_reg + 32'd1;

    always_comb
    begin
        state_next       = state_reg;
        body_start_next  = body_start_reg;
        cr_seen_next     = cr_seen_reg;
        n_res            = 2'd0;
        n_title          = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end

        case (state_reg)
            news_idx_pkg::ST_LF:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_LF;
                else if (up == news_idx_pkg::CHAR_S)
                    state_next = news_idx_pkg::ST_S;
                else if (c == news_idx_pkg::CHAR_PERIOD)
                    state_next = news_idx_pkg::ST_PERIOD;
                else
                    state_next = news_idx_pkg::ST_ROOT;
            end
            news_idx_pkg::ST_ROOT:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_LF;
            end
            news_idx_pkg::ST_ROOT_GOT:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_LF_GOT;
            end
            news_idx_pkg::ST_LF_GOT:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_LF_GOT;
                else if (c == news_idx_pkg::CHAR_PERIOD)
                    state_next = news_idx_pkg::ST_PERIOD;
                else
                    state_next = news_idx_pkg::ST_ROOT_GOT;
            end
            news_idx_pkg::ST_S, news_idx_pkg::ST_U, news_idx_pkg::ST_B,
            news_idx_pkg::ST_J, news_idx_pkg::ST_E, news_idx_pkg::ST_C:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_LF;
                else if (up == news_idx_pkg::kw_char(state_reg))
                    state_next = news_idx_pkg::scan_state_t'(4'(state_reg) + 4'd1);
                else
                    state_next = news_idx_pkg::ST_ROOT;
            end
            news_idx_pkg::ST_T:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_LF;
                else if (c == news_idx_pkg::CHAR_COLON)
                    state_next = news_idx_pkg::ST_COPY;
                else
                    state_next = news_idx_pkg::ST_ROOT;
            end
            news_idx_pkg::ST_COPY:
            begin
                if (eol)
                    state_next = news_idx_pkg::ST_ROOT_GOT;
                else
                begin
                    res[0].kind       = news_idx_pkg::KIND_TITLE;
                    res[0].title_byte = c;
                    n_title           = (room != '0) ? 2'd1 : 2'd0;
                end
            end
            news_idx_pkg::ST_PERIOD:
            begin
                if (eol)
                begin
                    res[0].kind           = news_idx_pkg::KIND_END;
                    res[0].article_start  = body_start_reg;
                    res[0].article_length = next_pos - body_start_reg;
                    res[0].line_end_is_cr = cr_seen_reg;
                    n_res                 = 2'd1;
                    state_next            = news_idx_pkg::ST_NAME;
                end
                else
                    state_next = news_idx_pkg::ST_ROOT;
            end
            default:
            begin
                // name line phase, also taken by unused codes
                if (eol)
                begin
                    cr_seen_next      = (c == news_idx_pkg::CHAR_CR);
                    res[0].title_byte = news_idx_pkg::CHAR_COLON;
                    res[1].title_byte = news_idx_pkg::CHAR_SPACE;
                    res[2].title_byte = news_idx_pkg::CHAR_SPACE;
                    if (room >= (CW+1)'(3))
                        n_title = 2'd3;
                    else
                        n_title = room[1:0];
                    body_start_next = next_pos;
                    state_next      = news_idx_pkg::ST_LF;
                end
                else
                begin
                    res[0].title_byte = c;
                    n_title           = (room != '0) ? 2'd1 : 2'd0;
                end
            end
        endcase

        if (n_title != 2'd0)
            n_res = n_title;

        if (n_res != 2'd0 && res[0].kind == news_idx_pkg::KIND_END)
            title_count_next = '0;
        else
            title_count_next = title_count_reg + CW'(n_title);

        for (int i = 0; i < 3; i++)
        begin
            res[i].last = (2'(i) + 2'd1 == n_res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            state_reg       <= news_idx_pkg::ST_NAME;
            pos_reg         <= '0;
            body_start_reg  <= '0;
            title_count_reg <= '0;
            cr_seen_reg     <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (proc_fire)
                in_valid_reg <= 1'b0;

            if (proc_fire)
            begin
                state_reg       <= state_next;
                pos_reg         <= next_pos;
                body_start_reg  <= body_start_next;
                title_count_reg <= title_count_next;
                cr_seen_reg     <= cr_seen_next;
                wr_ptr_reg      <= wr_ptr_reg + PW'(n_res);
            end

            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);

            count_reg <= count_reg + (proc_fire ? QW'(n_res) : QW'(0)) - QW'(pop);
        end
    end

    // hold the byte while the scan stage is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= data_byte;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (proc_fire && (2'(i) < n_res))
                queue_mem[wr_ptr_reg + PW'(i)] <= res[i];
        end
    end

    assign out_valid      = (count_reg != '0);
    assign kind           = queue_mem[rd_ptr_reg].kind;
    assign title_byte     = queue_mem[rd_ptr_reg].title_byte;
    assign article_start  = queue_mem[rd_ptr_reg].article_start;
    assign article_length = queue_mem[rd_ptr_reg].article_length;
    assign line_end_is_cr = queue_mem[rd_ptr_reg].line_end_is_cr;
    assign last           = queue_mem[rd_ptr_reg].last;

endmodule
